// ===== hdl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF         = 16;
    localparam int PAYLOAD_WIDTH_DEF = 32;
    localparam int PRIO_WIDTH_DEF    = 16;

    localparam int CAP_W     = 5;
    localparam int CAP_RESET = 16;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    localparam logic [CMD_W-1:0] CMD_ENQ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic                load;
        logic                finish;
        logic                insert;
        logic                remove;
        logic                front;
        logic                clear;
        logic [STATUS_W-1:0] status;
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             empty;
        logic             full;
    } stat_t;

endpackage

`default_nettype wire

// ===== hdl/spq_ifs.sv =====
`default_nettype none

interface spq_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [spq_pkg::CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spq_req_if #(
    parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEF,
    parameter int PRIO_WIDTH    = spq_pkg::PRIO_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [spq_pkg::CMD_W-1:0]     cmd;
    logic [PAYLOAD_WIDTH-1:0]      payload;
    logic signed [PRIO_WIDTH-1:0]  prio;

    modport source (output valid, output cmd, output payload, output prio, input ready);
    modport sink (input valid, input cmd, input payload, input prio, output ready);
endinterface

interface spq_res_if #(
    parameter int DEPTH         = spq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEF,
    parameter int PRIO_WIDTH    = spq_pkg::PRIO_WIDTH_DEF
);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                          valid;
    logic                          ready;
    logic [spq_pkg::STATUS_W-1:0]  status;
    logic [PAYLOAD_WIDTH-1:0]      out_payload;
    logic signed [PRIO_WIDTH-1:0]  out_prio;
    logic [CNT_W-1:0]              entry_count;
    logic                          is_full;
    logic                          is_empty;

    modport source (
        output valid, output status, output out_payload, output out_prio,
        output entry_count, output is_full, output is_empty, input ready
    );
    modport sink (
        input valid, input status, input out_payload, input out_prio,
        input entry_count, input is_full, input is_empty, output ready
    );
endinterface

`default_nettype wire

// ===== hdl/spq_datapath.sv =====
`default_nettype none

module spq_datapath #(
    parameter int DEPTH         = spq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEF,
    parameter int PRIO_WIDTH    = spq_pkg::PRIO_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [spq_pkg::CAP_W-1:0]          cfg_data,
    input  wire logic [spq_pkg::CMD_W-1:0]          cmd,
    input  wire logic [PAYLOAD_WIDTH-1:0]           payload,
    input  wire logic signed [PRIO_WIDTH-1:0]       prio,
    input  wire spq_pkg::ctl_t                      ctl,
    output spq_pkg::stat_t                          stat,
    output logic [spq_pkg::STATUS_W-1:0]            status,
    output logic [PAYLOAD_WIDTH-1:0]                out_payload,
    output logic signed [PRIO_WIDTH-1:0]            out_prio,
    output logic [$clog2(DEPTH+1)-1:0]              entry_count,
    output logic                                    is_full,
    output logic                                    is_empty
);

    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int EW      = (CNT_W > spq_pkg::CAP_W) ? CNT_W : spq_pkg::CAP_W;
    localparam int CAP_DEF = (spq_pkg::CAP_RESET > DEPTH) ? DEPTH : spq_pkg::CAP_RESET;

    logic [spq_pkg::CMD_W-1:0]    cmd_reg;
    logic [PAYLOAD_WIDTH-1:0]     pay_reg;
    logic signed [PRIO_WIDTH-1:0] prio_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [CNT_W-1:0]             cap_reg;
    logic [CNT_W-1:0]             cap_next;
    logic [EW-1:0]                cfg_ext;

    logic [PAYLOAD_WIDTH-1:0]     pay_q  [DEPTH];
    logic signed [PRIO_WIDTH-1:0] prio_q [DEPTH];
    logic [DEPTH-1:0]             ge;

    logic [spq_pkg::STATUS_W-1:0] status_reg;
    logic [PAYLOAD_WIDTH-1:0]     out_pay_reg;
    logic signed [PRIO_WIDTH-1:0] out_prio_reg;
    logic [CNT_W-1:0]             out_count_reg;
    logic                         full_reg;
    logic                         empty_reg;

    // capacity clamped on write
    assign cfg_ext = EW'(cfg_data);

    always_comb
    begin
        if (cfg_ext == '0)
        begin
            cap_next = CNT_W'(1);
        end
        else if (cfg_ext > EW'(DEPTH))
        begin
            cap_next = CNT_W'(DEPTH);
        end
        else
        begin
            cap_next = CNT_W'(cfg_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CNT_W'(CAP_DEF);
        end
        else if (cfg_write)
        begin
            cap_reg <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd;
            pay_reg  <= payload;
            prio_reg <= prio;
        end
    end

    assign stat.cmd   = cmd_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg >= cap_reg);

    // compare-and-shift cells
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            assign ge[i] = (CNT_W'(i) < count_reg) && (prio_q[i] >= prio_reg);

            always_ff @(posedge clk)
            begin
                if (ctl.insert && !ge[i])
                begin
                    if (i == 0)
                    begin
                        pay_q[i]  <= pay_reg;
                        prio_q[i] <= prio_reg;
                    end
                    else if (ge[(i == 0) ? 0 : i-1])
                    begin
                        pay_q[i]  <= pay_reg;
                        prio_q[i] <= prio_reg;
                    end
                    else
                    begin
                        pay_q[i]  <= pay_q[(i == 0) ? 0 : i-1];
                        prio_q[i] <= prio_q[(i == 0) ? 0 : i-1];
                    end
                end
                else if (ctl.remove && (i < DEPTH - 1))
                begin
                    pay_q[i]  <= pay_q[(i < DEPTH - 1) ? i+1 : i];
                    prio_q[i] <= prio_q[(i < DEPTH - 1) ? i+1 : i];
                end
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.finish)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            status_reg    <= ctl.status;
            out_pay_reg   <= ctl.front ? pay_q[0] : '0;
            out_prio_reg  <= ctl.front ? prio_q[0] : '0;
            out_count_reg <= count_next;
            full_reg      <= (count_next >= cap_reg);
            empty_reg     <= (count_next == '0);
        end
    end

    assign status      = status_reg;
    assign out_payload = out_pay_reg;
    assign out_prio    = out_prio_reg;
    assign entry_count = out_count_reg;
    assign is_full     = full_reg;
    assign is_empty    = empty_reg;

endmodule

`default_nettype wire

// ===== hdl/spq_ctrl.sv =====
`default_nettype none

module spq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire spq_pkg::stat_t stat,
    output spq_pkg::ctl_t       ctl
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;
    logic            res_valid_reg;
    logic            res_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = spq_pkg::ST_EXEC;
                end
            end
            spq_pkg::ST_EXEC:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        ctl      = '0;
        case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                in_ready = !res_valid_reg || out_ready;
                ctl.load = in_valid && in_ready;
            end
            spq_pkg::ST_EXEC:
            begin
                ctl.finish = 1'b1;
                ctl.status = spq_pkg::STATUS_OK;
                case (stat.cmd)
                    spq_pkg::CMD_ENQ:
                    begin
                        if (stat.full)
                        begin
                            ctl.status = spq_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            ctl.insert = 1'b1;
                        end
                    end
                    spq_pkg::CMD_DEQ, spq_pkg::CMD_PEEK:
                    begin
                        if (stat.empty)
                        begin
                            ctl.status = spq_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            ctl.front  = 1'b1;
                            ctl.remove = (stat.cmd == spq_pkg::CMD_DEQ);
                        end
                    end
                    spq_pkg::CMD_CLEAR:
                    begin
                        ctl.clear = 1'b1;
                    end
                    default:
                    begin
                        ctl.clear = 1'b0;
                    end
                endcase
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (ctl.finish)
        begin
            res_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign out_valid = res_valid_reg;

    a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> (state_reg == spq_pkg::ST_EXEC))
        else $error("load not followed by execute");

    a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |-> !res_valid_reg)
        else $error("result overwritten before taken");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !out_ready) |=> res_valid_reg)
        else $error("pending result dropped");

    a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({ctl.insert, ctl.remove, ctl.clear}) <= 1)
        else $error("conflicting queue updates");

endmodule

`default_nettype wire

// ===== hdl/sorted_priority_queue.sv =====
// channel  modport  fields                                                      accepted when
// cfg      sink     data (capacity_in_use)                                      valid && ready
// req      sink     cmd, payload, prio                                          valid && ready
// res      source   status, out_payload, out_prio, entry_count, is_full, is_empty  valid && ready
//
// a request is latched in the idle state; in the execute state the compare-and-shift array
// inserts or removes and the result register is loaded, and the next request waits for idle
// a new request is taken while the previous result waits, provided res.ready is high
// on the cycle of acceptance; a stalled result holds off further requests
// reset empties the queue and sets the capacity to 16, or to DEPTH if that is smaller; stored entries are not cleared
// cfg is always ready
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH         = spq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEF,
    parameter int PRIO_WIDTH    = spq_pkg::PRIO_WIDTH_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    spq_cfg_if.sink    cfg,
    spq_req_if.sink    req,
    spq_res_if.source  res
);

    spq_pkg::ctl_t  ctl;
    spq_pkg::stat_t stat;

    assign cfg.ready = 1'b1;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    spq_datapath #(
        .DEPTH         (DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
        .PRIO_WIDTH    (PRIO_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg.valid),
        .cfg_data    (cfg.data),
        .cmd         (req.cmd),
        .payload     (req.payload),
        .prio        (req.prio),
        .ctl         (ctl),
        .stat        (stat),
        .status      (res.status),
        .out_payload (res.out_payload),
        .out_prio    (res.out_prio),
        .entry_count (res.entry_count),
        .is_full     (res.is_full),
        .is_empty    (res.is_empty)
    );

endmodule

`default_nettype wire
